@@ hdl/sstq_pkg.sv @@
// Shared codes, command and status types for the sorted software timer queue.
package sstq_pkg;

  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_FREE  = 3'd1;
  localparam logic [2:0] REQ_INIT  = 3'd2;
  localparam logic [2:0] REQ_SET   = 3'd3;
  localparam logic [2:0] REQ_TICK  = 3'd4;

  localparam logic [1:0] KIND_OK  = 2'd0;
  localparam logic [1:0] KIND_ERR = 2'd1;
  localparam logic [1:0] KIND_EXP = 2'd2;
  localparam logic [1:0] KIND_TS  = 2'd3;

  localparam logic [5:0] LINK_NIL   = 6'h3f;
  localparam logic [5:0] TSS_NONE   = 6'd32;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_SIMPLE,
    CMD_SET_ARM,
    CMD_INS_PLACE,
    CMD_INS_MOVE,
    CMD_EMIT_OK_S,
    CMD_TICK_INC,
    CMD_EXPIRE,
    CMD_EMIT_PEND,
    CMD_EMIT_TS,
    CMD_EMIT_OK0
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic rd_walk;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       set_ok;
    logic       ins_hit;
    logic       exp_hit;
    logic       pend_v;
    logic       ts_v;
    logic       out_room;
  } stat_t;

endpackage

@@ hdl/sstq_dp.sv @@
// Datapath: slot state, sorted link list, tick counter and output register.
module sstq_dp import sstq_pkg::*; #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic        task_switch_slot_we_i,
  input  logic [5:0]  task_switch_slot_i,
  input  logic [2:0]  req_type_i,
  input  logic [4:0]  slot_id_i,
  input  logic [3:0]  dest_queue_i,
  input  logic [31:0] message_i,
  input  logic [31:0] delay_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [4:0]  slot_out_o,
  output logic [3:0]  dest_out_o,
  output logic [31:0] data_out_o,
  output logic        last_o
);

  localparam int NSLOT = (TIMER_SLOTS < 32) ? TIMER_SLOTS : 32;
  localparam int IW    = $clog2(NSLOT);

  logic [2:0]  req_q;
  logic [4:0]  sid_q;
  logic [3:0]  dest_q;
  logic [31:0] msg_q, dly_q;
  logic [31:0] tick_q, dlk_q;
  logic [5:0]  head_q, prev_q, tss_q;
  logic [NSLOT-1:0] busy_q, armed_q;
  logic [31:0] dl_arr [NSLOT];
  logic [31:0] msg_arr [NSLOT];
  logic [3:0]  dest_arr [NSLOT];
  logic [5:0]  link_arr [NSLOT];
  logic        pend_v_q, ts_v_q;
  logic [4:0]  pend_slot_q;
  logic [3:0]  pend_dest_q;
  logic [31:0] pend_msg_q;
  logic        out_valid_q, last_q;
  logic [1:0]  kind_q;
  logic [4:0]  slot_q;
  logic [3:0]  odest_q;
  logic [31:0] data_q;

  logic [IW-1:0] s_idx, h_idx, free_idx;
  logic          ok_slot, free_any, is_ts, ptr_nil, out_room;
  logic [5:0]    link_rd, ptr;
  logic [31:0]   dl_rd, dl_next;
  logic          emit, e_last;
  logic [1:0]    e_kind;
  logic [4:0]    e_slot;
  logic [3:0]    e_dest;
  logic [31:0]   e_data;

  assign s_idx    = sid_q[IW-1:0];
  assign ok_slot  = {1'b0, sid_q} < 6'(NSLOT);
  assign link_rd  = link_arr[cmd_i.rd_walk ? prev_q[IW-1:0] : head_q[IW-1:0]];
  assign ptr      = cmd_i.rd_walk ? link_rd : head_q;
  assign h_idx    = ptr[IW-1:0];
  assign ptr_nil  = (ptr == LINK_NIL);
  assign dl_rd    = dl_arr[h_idx];
  assign dl_next  = dly_q + tick_q;
  assign is_ts    = (ptr == tss_q);
  assign out_room = !out_valid_q || !out_stall_i;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    stat_o.req      = req_q;
    stat_o.set_ok   = ok_slot && busy_q[s_idx] && !armed_q[s_idx];
    stat_o.ins_hit  = ptr_nil || (dlk_q <= dl_rd);
    stat_o.exp_hit  = !ptr_nil && (dl_rd <= tick_q);
    stat_o.pend_v   = pend_v_q;
    stat_o.ts_v     = ts_v_q;
    stat_o.out_room = out_room;
  end

  always_comb begin
    emit   = 1'b0;
    e_kind = KIND_OK;
    e_slot = '0;
    e_dest = '0;
    e_data = '0;
    e_last = 1'b1;
    case (cmd_i.op)
      CMD_SIMPLE: begin
        emit = 1'b1;
        case (req_q)
          REQ_ALLOC: begin
            if (free_any) begin
              e_slot = 5'(free_idx);
            end else begin
              e_kind = KIND_ERR;
            end
          end
          REQ_FREE: begin
            e_slot = sid_q;
            if (!ok_slot || armed_q[s_idx]) e_kind = KIND_ERR;
          end
          REQ_INIT: begin
            e_slot = sid_q;
            if (!ok_slot) e_kind = KIND_ERR;
          end
          REQ_SET: begin
            e_slot = sid_q;
            e_kind = KIND_ERR;
          end
          default: e_kind = KIND_ERR;
        endcase
      end
      CMD_EMIT_OK_S: begin
        emit   = 1'b1;
        e_slot = sid_q;
      end
      CMD_EXPIRE: begin
        if (!is_ts && pend_v_q) begin
          emit   = 1'b1;
          e_kind = KIND_EXP;
          e_slot = pend_slot_q;
          e_dest = pend_dest_q;
          e_data = pend_msg_q;
          e_last = 1'b0;
        end
      end
      CMD_EMIT_PEND: begin
        emit   = 1'b1;
        e_kind = KIND_EXP;
        e_slot = pend_slot_q;
        e_dest = pend_dest_q;
        e_data = pend_msg_q;
        e_last = !ts_v_q;
      end
      CMD_EMIT_TS: begin
        emit   = 1'b1;
        e_kind = KIND_TS;
        e_slot = tss_q[4:0];
      end
      CMD_EMIT_OK0: emit = 1'b1;
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      busy_q      <= '0;
      armed_q     <= '0;
      head_q      <= LINK_NIL;
      tss_q       <= TSS_NONE;
      pend_v_q    <= 1'b0;
      ts_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (task_switch_slot_we_i) tss_q <= task_switch_slot_i;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        CMD_SIMPLE: begin
          if (req_q == REQ_ALLOC && free_any) busy_q[free_idx] <= 1'b1;
          if (req_q == REQ_FREE && ok_slot && !armed_q[s_idx]) busy_q[s_idx] <= 1'b0;
        end
        CMD_SET_ARM: armed_q[s_idx] <= 1'b1;
        CMD_INS_PLACE: begin
          if (!cmd_i.rd_walk) head_q <= {1'b0, sid_q};
        end
        CMD_TICK_INC: begin
          tick_q   <= tick_q + 32'd1;
          pend_v_q <= 1'b0;
          ts_v_q   <= 1'b0;
        end
        CMD_EXPIRE: begin
          armed_q[h_idx] <= 1'b0;
          head_q         <= link_arr[h_idx];
          if (is_ts) begin
            ts_v_q <= 1'b1;
          end else begin
            pend_v_q <= 1'b1;
          end
        end
        CMD_EMIT_PEND: pend_v_q <= 1'b0;
        CMD_EMIT_TS: ts_v_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= e_kind;
      slot_q  <= e_slot;
      odest_q <= e_dest;
      data_q  <= e_data;
      last_q  <= e_last;
    end
    case (cmd_i.op)
      CMD_LATCH: begin
        req_q  <= req_type_i;
        sid_q  <= slot_id_i;
        dest_q <= dest_queue_i;
        msg_q  <= message_i;
        dly_q  <= delay_i;
      end
      CMD_SIMPLE: begin
        if (req_q == REQ_INIT && ok_slot) begin
          dest_arr[s_idx] <= dest_q;
          msg_arr[s_idx]  <= msg_q;
        end
      end
      CMD_SET_ARM: begin
        dl_arr[s_idx] <= dl_next;
        dlk_q         <= dl_next;
        prev_q        <= head_q;
      end
      CMD_INS_PLACE: begin
        link_arr[s_idx] <= ptr;
        if (cmd_i.rd_walk) link_arr[prev_q[IW-1:0]] <= {1'b0, sid_q};
      end
      CMD_INS_MOVE: prev_q <= ptr;
      CMD_EXPIRE: begin
        if (!is_ts) begin
          pend_slot_q <= ptr[4:0];
          pend_dest_q <= dest_arr[h_idx];
          pend_msg_q  <= msg_arr[h_idx];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign slot_out_o  = slot_q;
  assign dest_out_o  = odest_q;
  assign data_out_o  = data_q;
  assign last_o      = last_q;

endmodule

@@ hdl/sstq_ctrl.sv @@
// Controller: sequences each request through the datapath.
module sstq_ctrl import sstq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_INS_HEAD, S_INS_WALK, S_DONE, S_EXP, S_EXP_END, S_TS
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = CMD_NONE;
    cmd_o.rd_walk = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LATCH;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.req == REQ_TICK) begin
          cmd_o.op = CMD_TICK_INC;
          state_d  = S_EXP;
        end else if (stat_i.req == REQ_SET && stat_i.set_ok) begin
          cmd_o.op = CMD_SET_ARM;
          state_d  = S_INS_HEAD;
        end else if (stat_i.out_room) begin
          cmd_o.op = CMD_SIMPLE;
          state_d  = S_IDLE;
        end
      end
      S_INS_HEAD, S_INS_WALK: begin
        cmd_o.rd_walk = (state_q == S_INS_WALK);
        if (stat_i.ins_hit) begin
          cmd_o.op = CMD_INS_PLACE;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = CMD_INS_MOVE;
          state_d  = S_INS_WALK;
        end
      end
      S_DONE: begin
        if (stat_i.out_room) begin
          cmd_o.op = CMD_EMIT_OK_S;
          state_d  = S_IDLE;
        end
      end
      S_EXP: begin
        if (stat_i.exp_hit) begin
          if (!stat_i.pend_v || stat_i.out_room) cmd_o.op = CMD_EXPIRE;
        end else begin
          state_d = S_EXP_END;
        end
      end
      S_EXP_END: begin
        if (stat_i.pend_v) begin
          if (stat_i.out_room) begin
            cmd_o.op = CMD_EMIT_PEND;
            state_d  = stat_i.ts_v ? S_TS : S_IDLE;
          end
        end else if (stat_i.ts_v) begin
          state_d = S_TS;
        end else if (stat_i.out_room) begin
          cmd_o.op = CMD_EMIT_OK0;
          state_d  = S_IDLE;
        end
      end
      S_TS: begin
        if (stat_i.out_room) begin
          cmd_o.op = CMD_EMIT_TS;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ hdl/sorted_software_timer_queue.sv @@
// Top level of the sorted software timer queue.
// Requests arrive as one item on the input channel (in_valid_i / in_stall_o)
// and every request produces one or more result items on the output channel
// (out_valid_o / out_stall_i); last_o marks the final result of a request.
// Allocate, free, init, a rejected set time and an unknown request are answered
// with a single result, written in the execute step after acceptance.
// Set time arms the slot, then walks the sorted list from its head, one list
// entry per step, until it finds the insert point; the walk over the
// single-read link and deadline register files sets the length of the walk.
// A tick increments the tick count, then removes each expired slot from the list
// head, each expiry using one list step, and reports an expired task switch slot last.
// The block works on one request at a time and holds in_stall_o high until
// the last result of the current request is in the output register.
// A full output register stalls the controller only at the steps that
// write a result, so a stalled receiver pauses the walk without loss.
// Reset empties the list, frees every slot, clears the tick count and sets
// the task switch slot to none; no clearing pass is needed.
// The task switch slot register is written whenever its write enable is
// high and should only change while the block is idle.
module sorted_software_timer_queue import sstq_pkg::*; #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        task_switch_slot_we_i,
  input  logic [5:0]  task_switch_slot_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [4:0]  slot_id_i,
  input  logic [3:0]  dest_queue_i,
  input  logic [31:0] message_i,
  input  logic [31:0] delay_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [4:0]  slot_out_o,
  output logic [3:0]  dest_out_o,
  output logic [31:0] data_out_o,
  output logic        last_o
);

  cmd_t  cmd;
  stat_t stat;

  // The controller owns sequencing; the datapath owns all request, slot and list storage.
  sstq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sstq_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .task_switch_slot_we_i (task_switch_slot_we_i),
    .task_switch_slot_i    (task_switch_slot_i),
    .req_type_i            (req_type_i),
    .slot_id_i             (slot_id_i),
    .dest_queue_i          (dest_queue_i),
    .message_i             (message_i),
    .delay_i               (delay_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .kind_o                (kind_o),
    .slot_out_o            (slot_out_o),
    .dest_out_o            (dest_out_o),
    .data_out_o            (data_out_o),
    .last_o                (last_o)
  );

  // An accepted item always keeps the block busy in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting an item");

  // No held expiry or task switch may remain once the block is idle.
  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!stat.pend_v && !stat.ts_v))
    else $error("pending expiry left behind at idle");

  // A result is only written when the output register has room.
  a_emit_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == CMD_SIMPLE || cmd.op == CMD_EMIT_OK_S || cmd.op == CMD_EMIT_PEND ||
     cmd.op == CMD_EMIT_TS || cmd.op == CMD_EMIT_OK0) |-> stat.out_room)
    else $error("result written over a stalled output");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the sorted software timer queue.
`timescale 1ns / 1ps

module testbench;
  import sstq_pkg::*;

  localparam int NSLOTS = 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic [3:0]  dest;
    logic [31:0] data;
    logic        last;
  } timer_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        task_switch_slot_we_i = 1'b0;
  logic [5:0]  task_switch_slot_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  req_type_i = '0;
  logic [4:0]  slot_id_i = '0;
  logic [3:0]  dest_queue_i = '0;
  logic [31:0] message_i = '0;
  logic [31:0] delay_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [4:0]  slot_out_o;
  logic [3:0]  dest_out_o;
  logic [31:0] data_out_o;
  logic        last_o;

  sorted_software_timer_queue dut (.*);

  always #5 clk_i = ~clk_i;

  // Local copy of the timer pool used to predict every result.
  logic [5:0]  switch_slot;
  logic [31:0] ticks;
  logic [1:0]  status  [NSLOTS];
  logic [31:0] due     [NSLOTS];
  logic [31:0] payload [NSLOTS];
  logic [3:0]  target  [NSLOTS];
  logic [5:0]  next_of [NSLOTS];
  logic        inited  [NSLOTS];
  logic [5:0]  head;

  timer_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int expiries_seen = 0;
  int items_sent = 0;
  bit stall_busy = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic timer_result_t mk(input logic [1:0] k, input logic [4:0] s,
                                       input logic [3:0] d, input logic [31:0] v);
    timer_result_t r;
    r.kind = k; r.slot = s; r.dest = d; r.data = v; r.last = 1'b0;
    return r;
  endfunction

  // Sorted insert: the new slot goes ahead of entries with an equal deadline.
  function automatic void link_sorted(input int s);
    int p;
    if (head == LINK_NIL || due[s] <= due[head]) begin
      next_of[s] = head;
      head = s[5:0];
      return;
    end
    p = head;
    while (next_of[p] != LINK_NIL && due[s] > due[next_of[p]]) p = next_of[p];
    next_of[s] = next_of[p];
    next_of[p] = s[5:0];
  endfunction

  function automatic void predict(input logic [2:0] req, input logic [4:0] s,
                                  input logic [3:0] d, input logic [31:0] msg,
                                  input logic [31:0] dly);
    timer_result_t out[$];
    bit switched;
    int h;
    switched = 1'b0;
    case (req)
      REQ_ALLOC: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (status[i] == 2'd0) begin
            status[i] = 2'd1;
            out.push_back(mk(KIND_OK, i[4:0], '0, '0));
            break;
          end
        end
        if (out.size() == 0) out.push_back(mk(KIND_ERR, '0, '0, '0));
      end
      REQ_FREE: begin
        if (status[s] == 2'd2) out.push_back(mk(KIND_ERR, s, '0, '0));
        else begin
          status[s] = 2'd0;
          out.push_back(mk(KIND_OK, s, '0, '0));
        end
      end
      REQ_INIT: begin
        target[s] = d; payload[s] = msg; inited[s] = 1'b1;
        out.push_back(mk(KIND_OK, s, '0, '0));
      end
      REQ_SET: begin
        if (status[s] != 2'd1) out.push_back(mk(KIND_ERR, s, '0, '0));
        else begin
          due[s] = dly + ticks;
          status[s] = 2'd2;
          link_sorted(s);
          out.push_back(mk(KIND_OK, s, '0, '0));
        end
      end
      REQ_TICK: begin
        ticks++;
        while (head != LINK_NIL && due[head] <= ticks) begin
          h = head;
          status[h] = 2'd1;
          if (h == switch_slot) switched = 1'b1;
          else out.push_back(mk(KIND_EXP, h[4:0], target[h], payload[h]));
          head = next_of[h];
        end
        if (switched) out.push_back(mk(KIND_TS, switch_slot[4:0], '0, '0));
        if (out.size() == 0) out.push_back(mk(KIND_OK, '0, '0, '0));
      end
      default: out.push_back(mk(KIND_ERR, '0, '0, '0));
    endcase
    out[out.size()-1].last = 1'b1;
    foreach (out[i]) pending_results.push_back(out[i]);
  endfunction

  // Gap length: mostly zero or short, occasionally long.
  function automatic int gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic [2:0] req, input logic [4:0] s,
                           input logic [3:0] d, input logic [31:0] msg,
                           input logic [31:0] dly);
    int g;
    g = gap();
    repeat (g) @(negedge clk_i);
    in_valid_i = 1'b1; req_type_i = req; slot_id_i = s;
    dest_queue_i = d; message_i = msg; delay_i = dly;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict(req, s, d, msg, dly);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (2 * NSLOTS + 10) @(negedge clk_i);
  endtask

  task automatic write_switch_slot(input logic [5:0] v);
    drain();
    task_switch_slot_we_i = 1'b1;
    task_switch_slot_i = v;
    switch_slot = v;
    @(negedge clk_i);
    task_switch_slot_we_i = 1'b0;
  endtask

  // Receiver side: stalls at random, with quiet stretches when stall_busy is low.
  always @(negedge clk_i) begin
    if (stall_busy) out_stall_i <= ($urandom_range(0, 99) < 30);
    else out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    timer_result_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {kind_o, slot_out_o, dest_out_o, data_out_o, last_o};
      results_seen++;
      if (kind_o == KIND_EXP) expiries_seen++;
      if (pending_results.size() == 0) report($sformatf("unexpected result %h", got));
      else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
        if (got.slot != want.slot) report($sformatf("slot %0d want %0d", got.slot, want.slot));
        if (got.dest != want.dest) report($sformatf("dest %0d want %0d", got.dest, want.dest));
        if (got.data != want.data) report($sformatf("data %h want %h", got.data, want.data));
        if (got.last != want.last) report($sformatf("last %0d want %0d", got.last, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** sorted_software_timer_queue: FAILED **");
      $finish;
    end
  end

  // Directed: error paths, pool exhaustion, wrap, equal deadlines.
  task automatic test_directed();
    send_item(REQ_TICK, '0, '0, '0, '0);
    send_item(3'd5, 5'd31, 4'hf, '1, '1);
    send_item(3'd7, '0, '0, '0, '0);
    send_item(REQ_FREE, 5'd31, '0, '0, '0);
    send_item(REQ_SET, 5'd0, '0, '0, 32'd1);
    for (int i = 0; i < NSLOTS; i++) begin
      send_item(REQ_ALLOC, '0, '0, '0, '0);
      send_item(REQ_INIT, i[4:0], i[3:0], $urandom, '0);
    end
    send_item(REQ_ALLOC, '0, '0, '0, '0);
    send_item(REQ_INIT, 5'd31, 4'hf, 32'hffffffff, '0);
    send_item(REQ_SET, 5'd3, '0, '0, 32'd2);
    send_item(REQ_SET, 5'd4, '0, '0, 32'd2);
    send_item(REQ_SET, 5'd5, '0, '0, 32'hffffffff);
    send_item(REQ_SET, 5'd31, '0, '0, 32'd0);
    send_item(REQ_SET, 5'd3, '0, '0, 32'd1);
    send_item(REQ_FREE, 5'd4, '0, '0, '0);
    send_item(REQ_TICK, '0, '0, '0, '0);
    send_item(REQ_TICK, '0, '0, '0, '0);
    send_item(REQ_FREE, 5'd4, '0, '0, '0);
    send_item(REQ_FREE, 5'd4, '0, '0, '0);
  endtask

  // Sets slots 0 to 7 and ticks once; a switch slot among them expires with them.
  task automatic test_switch_slot(input logic [5:0] sw);
    write_switch_slot(sw);
    for (int i = 0; i < 8; i++) send_item(REQ_SET, i[4:0], '0, '0, 32'd1);
    send_item(REQ_TICK, '0, '0, '0, '0);
  endtask

  // Random: mostly well-formed set/tick/free traffic on initialized slots.
  task automatic test_random(input int n);
    logic [2:0] req;
    logic [4:0] s;
    logic [31:0] dly;
    int r;
    stall_busy = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 50) stall_busy = ~stall_busy;
      r = $urandom_range(0, 99);
      s = 5'($urandom_range(0, NSLOTS - 1));
      if (r < 35) begin
        req = REQ_SET;
        dly = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
      end else if (r < 70) begin
        req = REQ_TICK; dly = $urandom;
      end else if (r < 80) begin
        req = REQ_ALLOC; dly = $urandom;
      end else if (r < 88) begin
        req = REQ_FREE; dly = $urandom;
      end else if (r < 96) begin
        req = REQ_INIT; dly = $urandom;
      end else begin
        req = 3'($urandom_range(5, 7)); dly = $urandom;
      end
      // Never arm a slot whose data was never written.
      if (req == REQ_SET && !inited[s]) req = REQ_INIT;
      send_item(req, s, 4'($urandom), $urandom, dly);
    end
    stall_busy = 1'b0;
  endtask

  initial begin
    switch_slot = TSS_NONE;
    ticks = '0;
    head = LINK_NIL;
    for (int i = 0; i < NSLOTS; i++) begin
      status[i] = 2'd0; due[i] = '0; payload[i] = '0;
      target[i] = '0; next_of[i] = '0; inited[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_switch_slot(6'd0);
    test_random(40);
    test_switch_slot(6'd31);
    test_random(40);
    test_switch_slot(6'd63);
    test_random(30);
    drain();

    $display("Sent %0d items; checked %0d results including %0d expiry messages.",
             items_sent, results_seen, expiries_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** sorted_software_timer_queue: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending_results.size());
      $display("** sorted_software_timer_queue: FAILED **");
    end
    $finish;
  end

endmodule
